### src/device_set_change_tracker_top_defines.svh
// Assertion macros for the change tracker.
`ifndef DEVICE_SET_CHANGE_TRACKER_TOP_DEFINES_SVH
`define DEVICE_SET_CHANGE_TRACKER_TOP_DEFINES_SVH
`ifndef SYNTH
`define DSCT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define DSCT_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DSCT_ASSERT(label, clk, rstn, prop, msg)
`define DSCT_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### src/dsct_pkg.sv
package dsct_pkg;
    localparam int TableDepthDefault = 32;
    localparam int SlotW  = 16;
    localparam int IdentW = 56;
    localparam int TotalW = 7;
    localparam logic [TotalW-1:0] TotalMax = 7'd127;

    typedef enum logic [1:0] {
        EV_ADDED   = 2'd0,
        EV_CHANGED = 2'd1,
        EV_REMOVED = 2'd2,
        EV_DONE    = 2'd3
    } ev_t;

    localparam logic [7:0] ClassStorage = 8'h01;
    localparam logic [7:0] ClassNetwork = 8'h02;
    localparam logic [7:0] ClassChar    = 8'h03;

    typedef struct packed {
        logic [SlotW-1:0]  slot;
        logic [IdentW-1:0] ident;
        logic              used;
        logic              matched;
    } entry_t;

    function automatic logic [1:0] kind_of_class(input logic [7:0] cls);
        logic [1:0] k;
        unique case (cls)
            ClassStorage: k = 2'd0;
            ClassNetwork: k = 2'd1;
            ClassChar:    k = 2'd2;
            default:      k = 2'd3;
        endcase
        return k;
    endfunction
endpackage

### src/dsct_cell.sv
// One ring position: holds an old entry and a new entry; the old entry rotates when shift_en is set.
module dsct_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift_en,
    input  logic              load_new,
    input  logic              commit,
    input  logic              set_match,
    input  dsct_pkg::entry_t  old_in,
    input  dsct_pkg::entry_t  new_in,
    output dsct_pkg::entry_t  old_out
);
    import dsct_pkg::*;
    entry_t old_reg, old_next, new_reg, new_next;

    always_comb begin
        old_next = old_reg;
        new_next = new_reg;
        if (commit) begin
            old_next = new_reg;
            old_next.matched = 1'b0;
            new_next.used = 1'b0;
        end else if (shift_en) begin
            old_next = old_in;
            if (set_match) old_next.matched = 1'b1;
            new_next = load_new ? new_in : new_reg;
        end else if (load_new) begin
            new_next = new_in;
        end
    end

    // Only the marks are reset; slot and identity are don't-care while unused.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            old_reg.used    <= 1'b0;
            old_reg.matched <= 1'b0;
            new_reg.used    <= 1'b0;
            new_reg.matched <= 1'b0;
        end else begin
            old_reg <= old_next;
            new_reg <= new_next;
        end
    end

    assign old_out = old_reg;
endmodule

### src/dsct_ctrl.sv
// Sequencer over the cell ring.
module dsct_ctrl #(
    parameter int TableDepth = dsct_pkg::TableDepthDefault
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            s_action,
    input  logic [dsct_pkg::SlotW-1:0]      s_slot,
    input  logic [dsct_pkg::IdentW-1:0]     s_ident,
    input  dsct_pkg::entry_t                head_old,
    output logic                            shift_en,
    output logic                            set_match,
    output logic                            commit,
    output logic [$clog2(TableDepth+1)-1:0] new_cnt,
    output logic                            wr_new,
    output dsct_pkg::entry_t                wr_entry,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata,
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);
    import dsct_pkg::*;
    localparam int CW = $clog2(TableDepth+1);
    localparam int SW = $clog2(TableDepth) + 1;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SWEEP, S_OUT, S_DONE} st_t;
    st_t state_reg;
    logic [CW-1:0] new_cnt_reg;
    logic [SW-1:0] step_reg;
    logic [TotalW-1:0] total_reg;
    logic [SlotW-1:0] slot_reg;
    logic [IdentW-1:0] ident_reg;
    logic found_reg, hitdiff_reg, out_v_reg;
    logic [63:0] out_reg;
    ev_t out_ev_reg;
    logic out_last_reg;

    // tdata layout: bus, dev, func, vendor, device id, kind, change count
    function automatic logic [63:0] pack_data(ev_t e, logic [SlotW-1:0] s,
                                              logic [IdentW-1:0] id, logic [TotalW-1:0] c);
        logic [63:0] r;
        r = '0;
        r[7:0]   = s[15:8];
        r[12:8]  = s[7:3];
        r[15:13] = s[2:0];
        r[31:16] = id[55:40];
        r[47:32] = id[39:24];
        r[49:48] = (e == EV_DONE) ? 2'd0 : kind_of_class(id[23:16]);
        r[56:50] = c;
        return r;
    endfunction

    logic [TotalW-1:0] total_inc;
    assign total_inc = (total_reg == TotalMax) ? total_reg : total_reg + 1'b1;

    assign s_tready = aresetn && (state_reg == S_IDLE) && !out_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = out_ev_reg;
    assign m_tlast  = out_last_reg;
    assign new_cnt  = new_cnt_reg;
    assign wr_entry = '{slot: s_slot, ident: s_ident, used: 1'b1, matched: 1'b0};

    logic in_acc, in_commit, scanning, hit_now, sweeping, out_free, gone_now, out_load;
    assign in_acc    = s_tvalid && s_tready;
    assign in_commit = in_acc && s_action;
    assign wr_new    = in_acc && !s_action && (new_cnt_reg != CW'(TableDepth));
    assign out_free  = !out_v_reg || m_tready;
    assign scanning  = (state_reg == S_SCAN);
    assign sweeping  = (state_reg == S_SWEEP);
    assign hit_now   = scanning && !found_reg && head_old.used && head_old.slot == slot_reg;
    assign set_match = hit_now;
    assign gone_now  = sweeping && head_old.used && !head_old.matched;
    // Sweep stalls when a removed event cannot be placed.
    assign shift_en  = scanning || (sweeping && (!gone_now || out_free));
    assign commit    = (state_reg == S_DONE) && out_free;
    assign out_load  = ((state_reg == S_OUT) && (!found_reg || hitdiff_reg)) ||
                       (gone_now && out_free) || commit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            new_cnt_reg <= '0;
            total_reg   <= '0;
            out_v_reg   <= 1'b0;
        end else begin
            if (out_load) out_v_reg <= 1'b1;
            else if (m_tready) out_v_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (in_commit) begin
                        state_reg <= S_SWEEP;
                        step_reg  <= '0;
                    end else if (wr_new) begin
                        new_cnt_reg <= new_cnt_reg + 1'b1;
                        slot_reg    <= s_slot;
                        ident_reg   <= s_ident;
                        found_reg   <= 1'b0;
                        hitdiff_reg <= 1'b0;
                        step_reg    <= '0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (hit_now) begin
                        found_reg   <= 1'b1;
                        hitdiff_reg <= head_old.ident != ident_reg;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == SW'(TableDepth-1)) state_reg <= S_OUT;
                end
                S_OUT: begin
                    state_reg <= S_IDLE;
                    if (!found_reg || hitdiff_reg) begin
                        out_reg      <= pack_data(found_reg ? EV_CHANGED : EV_ADDED,
                                                  slot_reg, ident_reg, '0);
                        out_ev_reg   <= found_reg ? EV_CHANGED : EV_ADDED;
                        out_last_reg <= 1'b1;
                        total_reg    <= total_inc;
                    end
                end
                S_SWEEP: begin
                    if (shift_en) begin
                        if (gone_now) begin
                            out_reg      <= pack_data(EV_REMOVED, head_old.slot,
                                                      head_old.ident, '0);
                            out_ev_reg   <= EV_REMOVED;
                            out_last_reg <= 1'b0;
                            total_reg    <= total_inc;
                        end
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == SW'(TableDepth-1)) state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        out_reg      <= pack_data(EV_DONE, '0, '0, total_reg);
                        out_ev_reg   <= EV_DONE;
                        out_last_reg <= 1'b1;
                        total_reg    <= '0;
                        new_cnt_reg  <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### src/dsct_ring.sv
// Ring of cells: old entries rotate through position 0, new entries load by index.
module dsct_ring #(
    parameter int TableDepth = dsct_pkg::TableDepthDefault
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            shift_en,
    input  logic                            set_match,
    input  logic                            commit,
    input  logic                            wr_new,
    input  logic [$clog2(TableDepth+1)-1:0] new_cnt,
    input  dsct_pkg::entry_t                wr_entry,
    output dsct_pkg::entry_t                head_old
);
    import dsct_pkg::*;
    localparam int CW = $clog2(TableDepth+1);
    entry_t old_q [TableDepth];
    entry_t old_d [TableDepth];

    for (genvar i = 0; i < TableDepth; i++) begin : g_cell
        entry_t nin;
        assign old_d[i] = old_q[i];
        assign nin = wr_entry;
        dsct_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .load_new (wr_new && (new_cnt == CW'(i))),
            .commit   (commit),
            .set_match(set_match && (i == TableDepth-1)),
            .old_in   (old_d[(i+1) % TableDepth]),
            .new_in   (nin),
            .old_out  (old_q[i])
        );
    end

    assign head_old = old_q[0];
endmodule

### src/device_set_change_tracker_top.sv
// Device set change tracker.
// s_ channel: one transfer per scan item. s_tuser is the action (0 entry,
// 1 end of scan and commit); s_tdata carries slot and identity.
// m_ channel: one transfer per event; m_tuser is the event (added, changed,
// removed, done) and m_tlast marks the final transfer caused by an input.
// Entry item: one rotation of the cell ring past the compare point in S_SCAN,
// then S_OUT loads the added or changed event into the output register; an
// unchanged entry makes no event, and an entry dropped on a full table is not
// scanned at all.
// End of scan: one rotation of the ring in S_SWEEP, held while a removed event
// waits on the receiver, then S_DONE sends the done transfer once the output is
// free; commit copies new to old in the same cycle in every cell.
// Reset clears counts, totals and the entry-used and matched marks; slot and
// identity contents are left as they are. s_tready is low during reset.
// A stalled receiver holds the sweep at the entry that waits to be sent;
// s_tready stays low until the output register is free. Items: one at a time.
module device_set_change_tracker_top #(
    parameter int TABLE_DEPTH = dsct_pkg::TableDepthDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // bus, dev, func, vendor, device_id, base class, subclass, prog_if
    input  logic [71:0] s_tdata,
    // action
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ev_bus, ev_dev, ev_func, ev_vendor, ev_device_id, device_kind,
    // change_count, zero fill
    output logic [63:0] m_tdata,
    // event_res
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    import dsct_pkg::*;
    localparam int CW = $clog2(TABLE_DEPTH+1);
    entry_t head_old, wr_entry;
    logic shift_en, set_match, commit, wr_new;
    logic [CW-1:0] new_cnt;
    // Slot as bus<<8|dev<<3|func; identity as vendor..prog_if.
    logic [SlotW-1:0]  in_slot;
    logic [IdentW-1:0] in_ident;
    assign in_slot  = {s_tdata[7:0], s_tdata[12:8], s_tdata[15:13]};
    assign in_ident = {s_tdata[31:16], s_tdata[47:32], s_tdata[55:48],
                       s_tdata[63:56], s_tdata[71:64]};

    dsct_ctrl #(.TableDepth(TABLE_DEPTH)) u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_action(s_tuser),
        .s_slot(in_slot), .s_ident(in_ident), .head_old,
        .shift_en, .set_match, .commit, .new_cnt, .wr_new, .wr_entry,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );
    dsct_ring #(.TableDepth(TABLE_DEPTH)) u_ring (
        .aclk, .aresetn, .shift_en, .set_match, .commit, .wr_new, .new_cnt,
        .wr_entry, .head_old
    );

`include "device_set_change_tracker_top_defines.svh"
    `DSCT_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
    `DSCT_ASSERT(a_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed")
    `DSCT_ASSERT(a_noacc, aclk, aresetn, m_tvalid |-> !s_tready, "input taken while busy")
    `DSCT_ASSERT_RST(a_rst, aclk, !aresetn |=> !m_tvalid, "valid after reset")
endmodule

### test/device_set_change_tracker_top_tb.sv
`timescale 1ns / 100ps

module device_set_change_tracker_top_tb;
    import dsct_pkg::*;

    localparam int Depth    = TableDepthDefault;
    localparam int Watchdog = 20000;

    typedef struct {
        logic       action;
        logic [7:0] bus;
        logic [4:0] dev;
        logic [2:0] func;
        logic [15:0] vendor;
        logic [15:0] device_id;
        logic [7:0] base_class;
        logic [7:0] subclass_code;
        logic [7:0] prog_if;
    } scan_item_t;

    typedef struct {
        ev_t         ev;
        logic [7:0]  bus;
        logic [4:0]  dev;
        logic [2:0]  func;
        logic [15:0] vendor;
        logic [15:0] device_id;
        logic [1:0]  kind;
        logic [6:0]  count;
        logic        last;
    } tracker_event_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // bus, dev, func, vendor, device_id, base class, subclass, prog_if
    logic [71:0] s_tdata;
    // action
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // ev_bus, ev_dev, ev_func, ev_vendor, ev_device_id, device_kind,
    // change_count, zero fill
    logic [63:0] m_tdata;
    // event_res
    logic [1:0]  m_tuser;
    logic        m_tlast;

    device_set_change_tracker_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow snapshot tables
    logic [15:0] prev_slot [Depth];
    logic [55:0] prev_ident[Depth];
    int          prev_count;
    logic [15:0] cur_slot  [Depth];
    logic [55:0] cur_ident [Depth];
    int          cur_count;
    bit          seen      [Depth];
    int          scan_changes;

    tracker_event_t pending_events[$];
    int errors;
    int items_sent;
    int events_seen;
    int scans_done;
    int full_drops;
    bit hold_off_req;
    int burst_left;

    // Stimulus helpers: a pool of slots so rescans hit old entries
    logic [15:0] slot_pool[48];
    logic [55:0] ident_of [logic [15:0]];

    function automatic logic [1:0] class_kind(logic [7:0] c);
        if (c == ClassStorage) return 2'd0;
        if (c == ClassNetwork) return 2'd1;
        if (c == ClassChar) return 2'd2;
        return 2'd3;
    endfunction

    function automatic tracker_event_t make_event(ev_t ev, logic [15:0] slot,
                                                  logic [55:0] ident);
        tracker_event_t e;
        e.ev        = ev;
        e.bus       = slot[15:8];
        e.dev       = slot[7:3];
        e.func      = slot[2:0];
        e.vendor    = ident[55:40];
        e.device_id = ident[39:24];
        e.kind      = class_kind(ident[23:16]);
        e.count     = '0;
        e.last      = 1'b1;
        return e;
    endfunction

    // Works out the events one accepted item causes and queues them
    task automatic predict_changes(scan_item_t it);
        logic [15:0] slot;
        logic [55:0] ident;
        tracker_event_t e;
        int hit;
        if (!it.action) begin
            slot  = {it.bus, it.dev, it.func};
            ident = {it.vendor, it.device_id, it.base_class, it.subclass_code, it.prog_if};
            if (cur_count >= Depth) begin
                full_drops++;
                return;
            end
            cur_slot[cur_count]  = slot;
            cur_ident[cur_count] = ident;
            cur_count++;
            hit = -1;
            for (int j = 0; j < prev_count; j++)
                if (prev_slot[j] == slot) begin
                    hit = j;
                    seen[j] = 1'b1;
                    break;
                end
            if (hit < 0)
                e = make_event(EV_ADDED, slot, ident);
            else if (prev_ident[hit] != ident)
                e = make_event(EV_CHANGED, slot, ident);
            else
                return;
            if (scan_changes < 127) scan_changes++;
            pending_events.push_back(e);
        end else begin
            for (int j = 0; j < prev_count; j++)
                if (!seen[j]) begin
                    e = make_event(EV_REMOVED, prev_slot[j], prev_ident[j]);
                    e.last = 1'b0;
                    pending_events.push_back(e);
                    if (scan_changes < 127) scan_changes++;
                end
            e = make_event(EV_DONE, '0, '0);
            e.kind  = '0;
            e.count = scan_changes[6:0];
            pending_events.push_back(e);
            prev_slot  = cur_slot;
            prev_ident = cur_ident;
            prev_count = cur_count;
            cur_count  = 0;
            scan_changes = 0;
            foreach (seen[j]) seen[j] = 1'b0;
            scans_done++;
        end
    endtask

    // One transfer on the input side; transfers come in bursts with gaps between
    task automatic send_item(scan_item_t it);
        s_tvalid <= 1'b1;
        s_tdata  <= {it.prog_if, it.subclass_code, it.base_class, it.device_id,
                     it.vendor, it.func, it.dev, it.bus};
        s_tuser  <= it.action;
        do @(posedge aclk); while (!s_tready);
        predict_changes(it);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    function automatic scan_item_t entry_item(logic [15:0] slot, logic [55:0] ident);
        scan_item_t it;
        it.action = 1'b0;
        {it.bus, it.dev, it.func} = slot;
        {it.vendor, it.device_id, it.base_class, it.subclass_code, it.prog_if} = ident;
        return it;
    endfunction

    function automatic scan_item_t commit_item();
        scan_item_t it;
        it = entry_item(16'($urandom), 56'({$urandom, $urandom}));
        it.action = 1'b1;
        return it;
    endfunction

    function automatic logic [55:0] random_ident();
        logic [55:0] id;
        logic [7:0] cls;
        id = 56'({$urandom, $urandom});
        case ($urandom_range(0, 4))
            0: cls = ClassStorage;
            1: cls = ClassNetwork;
            2: cls = ClassChar;
            default: cls = 8'($urandom);
        endcase
        id[23:16] = cls;
        return id;
    endfunction

    // One whole scan: entries drawn mostly from the slot pool, then commit
    task automatic run_scan(int n_entries);
        logic [15:0] slot;
        for (int k = 0; k < n_entries; k++) begin
            slot = ($urandom_range(0, 9) == 0) ? 16'($urandom) : slot_pool[$urandom_range(0, 47)];
            if (!ident_of.exists(slot) || $urandom_range(0, 3) == 0)
                ident_of[slot] = random_ident();
            send_item(entry_item(slot, ident_of[slot]));
        end
        send_item(commit_item());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (2 * Depth + 10) @(posedge aclk);
    endtask

    task automatic test_directed();
        logic [55:0] id_a;
        // empty commit straight after reset
        send_item(commit_item());
        // field extremes, each known device class
        send_item(entry_item(16'h0000, 56'h0));
        send_item(entry_item(16'hFFFF, {16'hFFFF, 16'hFFFF, ClassStorage, 8'hFF, 8'hFF}));
        send_item(entry_item(16'h0101, {16'h1234, 16'h5678, ClassNetwork, 8'h00, 8'h01}));
        send_item(entry_item(16'h0202, {16'hA5A5, 16'h5A5A, ClassChar, 8'h55, 8'h2A}));
        send_item(commit_item());
        // rescan: unchanged, changed, duplicate slot, one removed
        id_a = {16'h1234, 16'h5678, ClassNetwork, 8'h00, 8'h01};
        send_item(entry_item(16'h0000, 56'h0));
        send_item(entry_item(16'h0101, id_a));
        send_item(entry_item(16'h0101, id_a ^ 56'h1));
        send_item(entry_item(16'hFFFF, 56'h0));
        send_item(commit_item());
        // table full: one more entry than the table holds
        for (int k = 0; k <= Depth; k++)
            send_item(entry_item(16'(k * 8), random_ident()));
        send_item(commit_item());
        // everything removed
        send_item(commit_item());
        wait_drained();
    endtask

    task automatic test_random();
        while (items_sent < 320) begin
            case ($urandom_range(0, 9))
                0: run_scan($urandom_range(Depth, Depth + 3));
                1: run_scan(0);
                default: run_scan($urandom_range(1, 12));
            endcase
        end
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering a full scan
    task automatic test_output_stall();
        hold_off_req = 1'b1;
        run_scan(20);
        run_scan(4);
        wait_drained();
    endtask

    // Receiver: changes pattern every stretch; a long hold-off on request
    initial begin
        int stretch;
        int mode;
        int hold;
        m_tready <= 1'b0;
        stretch = 0;
        mode = 0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && hold == 0) begin
                hold = 300;
                hold_off_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                if (stretch == 0) begin
                    stretch = $urandom_range(5, 60);
                    mode = $urandom_range(0, 2);
                end
                stretch--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin
        tracker_event_t exp_ev;
        if (aresetn && m_tvalid && m_tready) begin
            events_seen++;
            if (pending_events.size() == 0) begin
                $error("unexpected result transfer, tdata=%h", m_tdata);
                errors++;
            end else begin
                exp_ev = pending_events.pop_front();
                if (m_tuser != exp_ev.ev) begin
                    $error("event_res exp %0d got %0d", exp_ev.ev, m_tuser); errors++;
                end
                if (m_tdata[7:0] != exp_ev.bus) begin
                    $error("ev_bus exp %h got %h", exp_ev.bus, m_tdata[7:0]); errors++;
                end
                if (m_tdata[12:8] != exp_ev.dev) begin
                    $error("ev_dev exp %h got %h", exp_ev.dev, m_tdata[12:8]); errors++;
                end
                if (m_tdata[15:13] != exp_ev.func) begin
                    $error("ev_func exp %h got %h", exp_ev.func, m_tdata[15:13]); errors++;
                end
                if (m_tdata[31:16] != exp_ev.vendor) begin
                    $error("ev_vendor exp %h got %h", exp_ev.vendor, m_tdata[31:16]);
                    errors++;
                end
                if (m_tdata[47:32] != exp_ev.device_id) begin
                    $error("ev_device_id exp %h got %h", exp_ev.device_id, m_tdata[47:32]);
                    errors++;
                end
                if (m_tdata[49:48] != exp_ev.kind) begin
                    $error("device_kind exp %0d got %0d", exp_ev.kind, m_tdata[49:48]);
                    errors++;
                end
                if (m_tdata[56:50] != exp_ev.count) begin
                    $error("change_count exp %0d got %0d", exp_ev.count, m_tdata[56:50]);
                    errors++;
                end
                if (m_tlast !== exp_ev.last) begin
                    $error("last exp %0d got %0d", exp_ev.last, m_tlast); errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
            if (idle >= Watchdog) begin
                $display("[device_set_change_tracker_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        errors = 0; items_sent = 0; events_seen = 0; scans_done = 0; full_drops = 0;
        prev_count = 0; cur_count = 0; scan_changes = 0; burst_left = 0;
        hold_off_req = 1'b0;
        foreach (seen[j]) seen[j] = 1'b0;
        foreach (slot_pool[k]) slot_pool[k] = 16'($urandom);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_output_stall();
        test_random();

        if (pending_events.size() != 0) begin
            $error("%0d expected results never arrived", pending_events.size());
            errors++;
        end
        $display("Run covered %0d items over %0d scans, %0d events checked, %0d table-full drops",
                 items_sent, scans_done, events_seen, full_drops);
        if (errors == 0)
            $display("[device_set_change_tracker_top] OK");
        else
            $display("[device_set_change_tracker_top] ERROR");
        $finish;
    end
endmodule

### files.f
+incdir+src
src/dsct_pkg.sv
src/dsct_cell.sv
src/dsct_ctrl.sv
src/dsct_ring.sv
src/device_set_change_tracker_top.sv
test/device_set_change_tracker_top_tb.sv
